// ===== design/bsc_pkg.sv =====
// shared types, register indexes and helpers for the barometric compensation block
// no dependencies
`default_nettype none

package bsc_pkg;

  localparam int unsigned DivW  = 32;
  localparam int unsigned SideW = 64;

  localparam logic [2:0] RegOss   = 3'd0;
  localparam logic [2:0] RegAc123 = 3'd1;
  localparam logic [2:0] RegAc456 = 3'd2;
  localparam logic [2:0] RegB12   = 3'd3;
  localparam logic [2:0] RegMcMd  = 3'd4;

  // one step of the restoring divider plus the item's sideband
  typedef struct packed {
    logic             valid;
    logic [DivW-1:0]  rem;
    logic [DivW-1:0]  quo;
    logic [DivW-1:0]  dvd;
    logic [DivW-1:0]  dsr;
    logic [SideW-1:0] side;
  } div_t;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [63:0] sdiv_p2(input logic signed [63:0] v,
                                                 input logic [5:0] k);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (v + bias) >>> k;
  endfunction

endpackage

`default_nettype wire

// ===== design/bsc_div_cell.sv =====
// one cell of the divider chain: one quotient bit per item per cycle while en_i is high
// depends on bsc_pkg
`default_nettype none

module bsc_div_cell (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire bsc_pkg::div_t d_i,
  output bsc_pkg::div_t     d_o
);

  bsc_pkg::div_t d_d, d_q;
  logic                   valid_q;
  logic [bsc_pkg::DivW:0] trial;
  logic                   ge;

  always_comb begin
    trial    = {d_i.rem, d_i.dvd[bsc_pkg::DivW-1]};
    ge       = trial >= {1'b0, d_i.dsr};
    d_d      = d_i;
    d_d.rem  = ge ? bsc_pkg::DivW'(trial - {1'b0, d_i.dsr})
                  : trial[bsc_pkg::DivW-1:0];
    d_d.quo  = {d_i.quo[bsc_pkg::DivW-2:0], ge};
    d_d.dvd  = {d_i.dvd[bsc_pkg::DivW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= d_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  // valid comes from the reset register, the rest from the data register
  assign d_o = {valid_q, d_q.rem, d_q.quo, d_q.dvd, d_q.dsr, d_q.side};

endmodule

`default_nettype wire

// ===== design/bsc_div_chain.sv =====
// row of divider cells, one per quotient bit
// depends on bsc_pkg and bsc_div_cell
`default_nettype none

module bsc_div_chain (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire bsc_pkg::div_t d_i,
  output bsc_pkg::div_t      d_o
);

  bsc_pkg::div_t link [bsc_pkg::DivW+1];

  assign link[0] = d_i;

  for (genvar g = 0; g < bsc_pkg::DivW; g++) begin : g_cell
    bsc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .d_i    (link[g]),
      .d_o    (link[g+1])
    );
  end

  assign d_o = link[bsc_pkg::DivW];

endmodule

`default_nettype wire

// ===== design/barometric_sensor_compensation.sv =====
// barometric compensation top level: config registers, arithmetic stages, two divider chains
// depends on bsc_pkg and bsc_div_chain
//
// usage
// - input channel in_valid_i/in_ready_o carries raw_temp_i and raw_press_i, one item per
//   handshake; output channel out_valid_o/out_ready_i carries temperature_o, pressure_o and
//   div_error_o, one result per item, in order
// - config channel cfg_valid_i/cfg_ready_o writes register cfg_index_i with cfg_data_i;
//   cfg_ready_o is always high, write only while no item is in flight
// - throughput is one item per cycle unless the receiver stalls; each item passes the two
//   32-cell divider chains (one quotient bit per cell) plus ten arithmetic stages
// - a zero divisor gives div_error_o high with both results zero
// - reset clears all config registers and empties the pipeline
// - when the receiver stalls the whole pipeline holds and in_ready_o falls; results in
//   flight are kept, nothing is dropped
`default_nettype none

module barometric_sensor_compensation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [47:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] raw_temp_i,
  input  wire logic [18:0] raw_press_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [15:0] temperature_o,
  output logic [19:0]      pressure_o,
  output logic             div_error_o
);

  logic [1:0]  oss_q;
  logic [47:0] ac123_q, ac456_q;
  logic [31:0] b12_q, mcmd_q;

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  logic en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q   <= '0;
      ac123_q <= '0;
      ac456_q <= '0;
      b12_q   <= '0;
      mcmd_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bsc_pkg::RegOss:   oss_q   <= cfg_data_i[1:0];
        bsc_pkg::RegAc123: ac123_q <= cfg_data_i;
        bsc_pkg::RegAc456: ac456_q <= cfg_data_i;
        bsc_pkg::RegB12:   b12_q   <= cfg_data_i[31:0];
        bsc_pkg::RegMcMd:  mcmd_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  assign ac1 = $signed(ac123_q[47:32]);
  assign ac2 = $signed(ac123_q[31:16]);
  assign ac3 = $signed(ac123_q[15:0]);
  assign ac4 = ac456_q[47:32];
  assign ac5 = ac456_q[31:16];
  assign ac6 = ac456_q[15:0];
  assign b1  = $signed(b12_q[31:16]);
  assign b2  = $signed(b12_q[15:0]);
  assign mc  = $signed(mcmd_q[31:16]);
  assign md  = $signed(mcmd_q[15:0]);

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage a: (ut - ac6) * ac5
  logic               a_valid_q;
  logic signed [33:0] a_prod_q;
  logic [18:0]        a_up_q;
  logic signed [16:0] a_diff;

  assign a_diff = $signed({1'b0, raw_temp_i}) - $signed({1'b0, ac6});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (en) a_valid_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_prod_q <= 34'(a_diff) * $signed({18'b0, ac5});
      a_up_q   <= raw_press_i;
    end
  end

  // x1, denominator and operands for the first divider
  logic signed [63:0] b_x1;
  logic signed [19:0] b_den;
  logic signed [26:0] b_num;
  logic [26:0]        b_nmag;
  logic [19:0]        b_dmag;
  bsc_pkg::div_t      div1_in, div1_out;

  always_comb begin
    b_x1   = bsc_pkg::sdiv_p2(64'(a_prod_q), 6'd15);
    b_den  = 20'(b_x1) + 20'(md);
    b_num  = {mc, 11'b0};
    b_nmag = b_num[26] ? 27'(-b_num) : b_num;
    b_dmag = b_den[19] ? 20'(-b_den) : b_den;
    div1_in.valid = a_valid_q;
    div1_in.rem   = '0;
    div1_in.quo   = '0;
    div1_in.dvd   = {5'b0, b_nmag};
    div1_in.dsr   = {12'b0, b_dmag};
    div1_in.side  = {24'b0, b_x1[18:0], a_up_q, b_den == 20'sd0, b_num[26] ^ b_den[19]};
  end

  bsc_div_chain u_div1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (div1_in), .d_o (div1_out)
  );

  // stage c: b5, temperature, b6
  logic               c_valid_q, c_err_q;
  logic signed [15:0] c_t_q;
  logic signed [29:0] c_b6_q;
  logic [18:0]        c_up_q;
  logic signed [29:0] c_x2, c_b5;
  logic signed [63:0] c_t;
  logic signed [15:0] c_tsat;

  always_comb begin
    c_x2 = div1_out.side[0] ? -$signed({3'b0, div1_out.quo[26:0]})
                            : $signed({3'b0, div1_out.quo[26:0]});
    c_b5 = 30'($signed(div1_out.side[39:21])) + c_x2;
    c_t  = bsc_pkg::sdiv_p2(64'(c_b5) + 64'sd8, 6'd4);
    if (c_t > 64'sd32767) c_tsat = 16'sh7fff;
    else if (c_t < -64'sd32768) c_tsat = -16'sh8000;
    else c_tsat = c_t[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else if (en) c_valid_q <= div1_out.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_t_q   <= c_tsat;
      c_b6_q  <= c_b5 - 30'sd4000;
      c_up_q  <= div1_out.side[20:2];
      c_err_q <= div1_out.side[1];
    end
  end

  // stage d: b6 squared and coefficient products
  logic               d_valid_q, d_err_q;
  logic signed [15:0] d_t_q;
  logic [18:0]        d_up_q;
  logic signed [59:0] d_sqp_q;
  logic signed [45:0] d_ac2b6_q, d_ac3b6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else if (en) d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sqp_q   <= 60'(c_b6_q) * 60'(c_b6_q);
      d_ac2b6_q <= 46'(ac2) * 46'(c_b6_q);
      d_ac3b6_q <= 46'(ac3) * 46'(c_b6_q);
      d_t_q     <= c_t_q;
      d_up_q    <= c_up_q;
      d_err_q   <= c_err_q;
    end
  end

  // stage e: b1 and b2 times sq
  logic               e_valid_q, e_err_q;
  logic signed [15:0] e_t_q;
  logic [18:0]        e_up_q;
  logic signed [63:0] e_b2sq_q, e_b1sq_q;
  logic signed [45:0] e_ac2b6_q, e_ac3b6_q;
  logic signed [63:0] e_sq;

  assign e_sq = 64'(d_sqp_q >>> 12);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_valid_q <= 1'b0;
    else if (en) e_valid_q <= d_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_b2sq_q  <= 64'(b2) * e_sq;
      e_b1sq_q  <= 64'(b1) * e_sq;
      e_ac2b6_q <= d_ac2b6_q;
      e_ac3b6_q <= d_ac3b6_q;
      e_t_q     <= d_t_q;
      e_up_q    <= d_up_q;
      e_err_q   <= d_err_q;
    end
  end

  // stage f: the two x3 sums
  logic               f_valid_q, f_err_q;
  logic signed [15:0] f_t_q;
  logic [18:0]        f_up_q;
  logic signed [63:0] f_x3_q, f_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_valid_q <= 1'b0;
    else if (en) f_valid_q <= e_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_x3_q  <= bsc_pkg::sdiv_p2(e_b2sq_q, 6'd11)
               + bsc_pkg::sdiv_p2(64'(e_ac2b6_q), 6'd11);
      f_y_q   <= bsc_pkg::sdiv_p2(64'(e_ac3b6_q), 6'd13)
               + bsc_pkg::sdiv_p2(e_b1sq_q, 6'd16);
      f_t_q   <= e_t_q;
      f_up_q  <= e_up_q;
      f_err_q <= e_err_q;
    end
  end

  // stage g: b3 and the b4 operand
  logic               g_valid_q, g_err_q;
  logic signed [15:0] g_t_q;
  logic [18:0]        g_up_q;
  logic signed [63:0] g_b3_q, g_x3b_q;
  logic signed [63:0] g_scaled;

  assign g_scaled = ((64'(ac1) * 64'sd4 + f_x3_q) <<< oss_q) + 64'sd2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_valid_q <= 1'b0;
    else if (en) g_valid_q <= f_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_b3_q  <= bsc_pkg::sdiv_p2(g_scaled, 6'd2);
      g_x3b_q <= bsc_pkg::sdiv_p2(f_y_q + 64'sd2, 6'd2);
      g_t_q   <= f_t_q;
      g_up_q  <= f_up_q;
      g_err_q <= f_err_q;
    end
  end

  // stage h: b4 and b7, both modulo 2^32
  logic               h_valid_q, h_err_q;
  logic signed [15:0] h_t_q;
  logic [31:0]        h_b4_q, h_b7_q;
  logic [63:0]        h_x3bp;
  logic [31:0]        h_diff;
  logic [47:0]        h_prod4, h_prod7;

  always_comb begin
    h_x3bp  = 64'(g_x3b_q + 64'sd32768);
    h_prod4 = 48'(ac4) * 48'(h_x3bp[31:0]);
    h_diff  = 32'(g_up_q) - g_b3_q[31:0];
    h_prod7 = 48'(h_diff) * 48'(17'd50000 >> oss_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) h_valid_q <= 1'b0;
    else if (en) h_valid_q <= g_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_b4_q  <= {15'b0, h_prod4[31:15]};
      h_b7_q  <= h_prod7[31:0];
      h_t_q   <= g_t_q;
      h_err_q <= g_err_q;
    end
  end

  // b7 with its top bit set divides first and doubles after
  bsc_pkg::div_t div2_in, div2_out;

  always_comb begin
    div2_in.valid = h_valid_q;
    div2_in.rem   = '0;
    div2_in.quo   = '0;
    div2_in.dvd   = h_b7_q[31] ? h_b7_q : {h_b7_q[30:0], 1'b0};
    div2_in.dsr   = h_b4_q;
    div2_in.side  = {46'b0, h_t_q, h_err_q || (h_b4_q == 32'd0), h_b7_q[31]};
  end

  bsc_div_chain u_div2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .d_i (div2_in), .d_o (div2_out)
  );

  // stage i: pressure base and products
  logic               i_valid_q, i_err_q;
  logic signed [15:0] i_t_q;
  logic [31:0]        i_p_q;
  logic [47:0]        i_sq2_q;
  logic signed [63:0] i_m2_q;
  logic [31:0]        i_q;

  assign i_q = div2_out.side[0] ? {div2_out.quo[30:0], 1'b0} : div2_out.quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) i_valid_q <= 1'b0;
    else if (en) i_valid_q <= div2_out.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_p_q   <= i_q;
      i_sq2_q <= 48'(i_q[31:8]) * 48'(i_q[31:8]);
      i_m2_q  <= -64'sd7357 * $signed(64'(i_q));
      i_t_q   <= div2_out.side[17:2];
      i_err_q <= div2_out.side[1];
    end
  end

  // stage j: scale the correction terms
  logic               j_valid_q, j_err_q;
  logic signed [15:0] j_t_q;
  logic [31:0]        j_p_q;
  logic [63:0]        j_x1_q;
  logic signed [63:0] j_x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) j_valid_q <= 1'b0;
    else if (en) j_valid_q <= i_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_x1_q  <= (64'(i_sq2_q) * 64'd3038) >> 16;
      j_x2_q  <= bsc_pkg::sdiv_p2(i_m2_q, 6'd16);
      j_p_q   <= i_p_q;
      j_t_q   <= i_t_q;
      j_err_q <= i_err_q;
    end
  end

  // output register: final correction, saturation, error zeroing
  logic signed [63:0] k_p;
  logic [19:0]        k_psat;

  always_comb begin
    k_p = $signed(64'(j_p_q))
        + bsc_pkg::sdiv_p2($signed(j_x1_q) + j_x2_q + 64'sd3791, 6'd4);
    if (k_p < 64'sd0) k_psat = '0;
    else if (k_p > 64'sd1048575) k_psat = 20'hfffff;
    else k_psat = k_p[19:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= j_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      temperature_o <= j_err_q ? 16'sd0 : j_t_q;
      pressure_o    <= j_err_q ? 20'd0 : k_psat;
      div_error_o   <= j_err_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && div_error_o) |-> (temperature_o == 16'sd0 && pressure_o == 20'd0))
    else $error("error item carries nonzero results");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready out of step with output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> ($stable(a_valid_q) && $stable(j_valid_q)))
    else $error("pipeline moved during stall");
`endif

endmodule

`default_nettype wire
